FILE: design/csched_pkg.sv
// Shared types and constants for the cooperative task scheduler.
// Holds the slot table sizing, item codes and controller/datapath link types.
// No dependencies.
package csched_pkg;

    // Table sizing
    localparam int MAX_TASKS  = 8;
    localparam int RESULT_CAP = 8;
    localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    // Field widths
    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int PEND_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [PEND_W-1:0] PENDING_MAX = 8'hFF;

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_DELETE   = 2'd3
    } t_mode;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic walk_item;
        logic walk_last;
        logic stall;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: design/csched_ctrl.sv
// Sequencing controller for the cooperative task scheduler.
// Issues load, slot-walk and finish commands to the datapath. Uses csched_pkg.
module csched_ctrl import csched_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.walk_item ? S_WALK : S_FINISH;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (!i_stat.stall && i_stat.walk_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/csched_dp.sv
// Datapath for the cooperative task scheduler: slot table, walk index,
// held dispatch result and output register. Uses csched_pkg.
module csched_dp import csched_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [MODE_W-1:0]    i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STAT_W-1:0]    o_m_tuser,
    output logic                 o_m_tlast
);

    // Slot table
    logic [ID_W-1:0]   r_task    [MAX_TASKS], n_task    [MAX_TASKS];
    logic [TIME_W-1:0] r_delay   [MAX_TASKS], n_delay   [MAX_TASKS];
    logic [TIME_W-1:0] r_period  [MAX_TASKS], n_period  [MAX_TASKS];
    logic [PEND_W-1:0] r_pending [MAX_TASKS], n_pending [MAX_TASKS];

    // Latched item
    t_mode             r_mode, n_mode;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_dly, n_dly;
    logic [TIME_W-1:0] r_per, n_per;
    logic [SLOT_W-1:0] r_sidx, n_sidx;

    // Walk control
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Held dispatch result, waiting to learn whether it is the last
    logic              r_hold_valid, n_hold_valid;
    logic [ID_W-1:0]   r_hold_task, n_hold_task;
    logic [SLOT_W-1:0] r_hold_slot, n_hold_slot;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_task, n_out_task;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_last, n_out_last;

    // Current slot and helpers
    logic [ID_W-1:0]   cur_task;
    logic [TIME_W-1:0] cur_delay;
    logic [TIME_W-1:0] cur_period;
    logic [PEND_W-1:0] cur_pend;
    logic              out_free;
    logic              walk_last;
    logic              disp_ready;
    logic              stall;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              del_ok;
    logic [IDX_W-1:0]  del_idx;

    assign cur_task   = r_task[r_idx];
    assign cur_delay  = r_delay[r_idx];
    assign cur_period = r_period[r_idx];
    assign cur_pend   = r_pending[r_idx];

    assign out_free   = !r_out_valid || i_m_tready;
    assign walk_last  = (r_idx == IDX_W'(MAX_TASKS - 1));
    assign disp_ready = (cur_pend != '0) && (r_cnt < CNT_W'(RESULT_CAP));
    // Only acted on during the walk
    assign stall      = (r_mode == MODE_DISPATCH) && disp_ready && r_hold_valid && !out_free;

    assign del_ok     = (int'(r_sidx) < MAX_TASKS);
    assign del_idx    = IDX_W'(r_sidx);

    // Status to controller
    assign o_stat.walk_item = (i_s_tuser == MODE_TICK) || (i_s_tuser == MODE_DISPATCH);
    assign o_stat.walk_last = walk_last;
    assign o_stat.stall     = stall;
    assign o_stat.out_free  = out_free;

    // First empty slot for add
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_task[i] == '0) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Next-state logic
    always_comb begin
        logic              push;
        logic [STAT_W-1:0] p_status;
        logic [ID_W-1:0]   p_task;
        logic [SLOT_W-1:0] p_slot;
        logic              p_last;

        push     = 1'b0;
        p_status = ST_DONE;
        p_task   = '0;
        p_slot   = '0;
        p_last   = 1'b1;

        n_task       = r_task;
        n_delay      = r_delay;
        n_period     = r_period;
        n_pending    = r_pending;
        n_mode       = r_mode;
        n_id         = r_id;
        n_dly        = r_dly;
        n_per        = r_per;
        n_sidx       = r_sidx;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_hold_valid = r_hold_valid;
        n_hold_task  = r_hold_task;
        n_hold_slot  = r_hold_slot;

        // Latch a new item
        if (i_cmd.load) begin
            n_mode       = t_mode'(i_s_tuser);
            n_id         = i_s_tdata[7:0];
            n_dly        = i_s_tdata[23:8];
            n_per        = i_s_tdata[39:24];
            n_sidx       = i_s_tdata[42:40];
            n_idx        = '0;
            n_cnt        = '0;
            n_hold_valid = 1'b0;
        end

        // One slot of a tick or dispatch walk
        if (i_cmd.step && !stall) begin
            if (r_mode == MODE_TICK) begin
                if (cur_task != '0) begin
                    if (cur_delay == '0) begin
                        if (cur_pend != PENDING_MAX) begin
                            n_pending[r_idx] = cur_pend + PEND_W'(1);
                        end
                        if (cur_period != '0) begin
                            n_delay[r_idx] = cur_period;
                        end
                    end else begin
                        n_delay[r_idx] = cur_delay - TIME_W'(1);
                    end
                end
            end else if (disp_ready) begin
                if (r_hold_valid) begin
                    push     = 1'b1;
                    p_status = ST_DONE;
                    p_task   = r_hold_task;
                    p_slot   = r_hold_slot;
                    p_last   = 1'b0;
                end
                n_hold_valid     = 1'b1;
                n_hold_task      = cur_task;
                n_hold_slot      = SLOT_W'(r_idx);
                n_cnt            = r_cnt + CNT_W'(1);
                n_pending[r_idx] = cur_pend - PEND_W'(1);
                if (cur_period == '0) begin
                    n_task[r_idx]    = '0;
                    n_delay[r_idx]   = '0;
                    n_period[r_idx]  = '0;
                    n_pending[r_idx] = '0;
                end
            end
            if (!walk_last) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end

        // Final result of the item
        if (i_cmd.finish && out_free) begin
            push = 1'b1;
            unique case (r_mode)
                MODE_TICK: begin
                    p_status = ST_DONE;
                end
                MODE_ADD: begin
                    if (r_id == '0) begin
                        p_status = ST_DONE;
                    end else if (free_found) begin
                        n_task[free_idx]    = r_id;
                        n_delay[free_idx]   = r_dly;
                        n_period[free_idx]  = r_per;
                        n_pending[free_idx] = '0;
                        p_status            = ST_DONE;
                        p_slot              = SLOT_W'(free_idx);
                    end else begin
                        p_status = ST_FULL;
                    end
                end
                MODE_DISPATCH: begin
                    if (r_hold_valid) begin
                        p_status     = ST_DONE;
                        p_task       = r_hold_task;
                        p_slot       = r_hold_slot;
                        n_hold_valid = 1'b0;
                    end else begin
                        p_status = ST_NONE;
                    end
                end
                MODE_DELETE: begin
                    if (del_ok) begin
                        n_task[del_idx]    = '0;
                        n_delay[del_idx]   = '0;
                        n_period[del_idx]  = '0;
                        n_pending[del_idx] = '0;
                    end
                    p_status = ST_DONE;
                end
                default: p_status = ST_DONE;
            endcase
        end

        // Output register: load on push, drain on take
        n_out_status = r_out_status;
        n_out_task   = r_out_task;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid;
        if (push) begin
            n_out_valid  = 1'b1;
            n_out_status = p_status;
            n_out_task   = p_task;
            n_out_slot   = p_slot;
            n_out_last   = p_last;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state and slot table, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_task[i]    <= '0;
                r_delay[i]   <= '0;
                r_period[i]  <= '0;
                r_pending[i] <= '0;
            end
            r_idx        <= '0;
            r_cnt        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_TICK;
        end else begin
            r_task       <= n_task;
            r_delay      <= n_delay;
            r_period     <= n_period;
            r_pending    <= n_pending;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            r_mode       <= n_mode;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_dly        <= n_dly;
        r_per        <= n_per;
        r_sidx       <= n_sidx;
        r_hold_task  <= n_hold_task;
        r_hold_slot  <= n_hold_slot;
        r_out_status <= n_out_status;
        r_out_task   <= n_out_task;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - ID_W - SLOT_W)'(0), r_out_slot, r_out_task};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: design/cooperative_task_scheduler.sv
// Time-triggered cooperative task scheduler, top level.
// Tick and dispatch walk one slot per cycle between accept and finish, unless a dispatch
// beat waits on a busy output; add and delete go from accept straight to finish. The final
// result is registered in the finish state, after the walk (after accept for add/delete);
// earlier dispatch beats leave during the walk, each once the next ready slot is found.
// Synchronous active-low reset empties every slot and drops any result in flight.
module cooperative_task_scheduler import csched_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // task_id, start_delay, repeat_period, slot_index
    input  logic [MODE_W-1:0]    i_s_tuser,  // mode
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // run_task, slot_used
    output logic [STAT_W-1:0]    o_m_tuser,  // status
    output logic                 o_m_tlast   // last beat of the item's results
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    csched_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Slot table and result path
    csched_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
